// ----- src/ord_pkg.sv -----
package ord_pkg;

	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [1:0] OP_PUSH_BACK = 2'd0;
	localparam logic [1:0] OP_POP_FRONT = 2'd1;
	localparam logic [1:0] OP_POP_BACK  = 2'd2;

	// returned by a pop on an empty ring
	localparam logic signed [31:0] EMPTY_WORD = -32'sd251152;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic               status;
		logic               now_empty;
		logic               now_full;
	} rsp_t;

	// registered result control from the pointer stage
	typedef struct packed {
		logic valid;
		logic from_mem;
		logic status;
		logic now_empty;
		logic now_full;
	} ctl_t;

endpackage

// ----- src/ord_mem.sv -----
module ord_mem #(
	parameter int DEPTH = 16,
	parameter int PTR_W = 4
) (
	input  logic                clk,
	input  logic                we,
	input  logic [PTR_W-1:0]    waddr,
	input  logic signed [31:0]  wdata,
	input  logic [PTR_W-1:0]    raddr,
	output logic signed [31:0]  rdata
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/ord_ctrl.sv -----
module ord_ctrl #(
	parameter int DEPTH = 16,
	parameter int PTR_W = 4,
	parameter int CNT_W = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  ord_pkg::cmd_t                cmd,
	input  logic                         cfg_we,
	input  logic [ord_pkg::CAP_W-1:0]    cfg_wdata,
	output logic                         mem_we,
	output logic [PTR_W-1:0]             mem_waddr,
	output logic signed [31:0]           mem_wdata,
	output logic [PTR_W-1:0]             mem_raddr,
	output ord_pkg::ctl_t                ctl_s2
);

	localparam int CMP_W = CNT_W + 1;
	localparam logic [CNT_W-1:0] CAP_RST_EFF =
		(int'(ord_pkg::CAP_RESET) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(ord_pkg::CAP_RESET);

	logic                 valid_s1;
	ord_pkg::cmd_t        cmd_s1;
	logic [CNT_W-1:0]     cap_q;
	logic [PTR_W-1:0]     head_q, tail_q;
	logic [CNT_W-1:0]     count_q;

	logic [CNT_W-1:0]     cap_eff;
	logic [PTR_W-1:0]     head_nxt, tail_nxt, head_inc, tail_inc, tail_dec;
	logic [CNT_W-1:0]     count_nxt;
	logic                 is_full, is_empty, from_mem, pop_fail;

	// clamp a written capacity into 1..DEPTH
	always_comb begin
		if (cfg_wdata == '0) begin
			cap_eff = CNT_W'(1);
		end else if (int'(cfg_wdata) > DEPTH) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(cfg_wdata);
		end
	end

	// ring index steps within the capacity in use
	assign head_inc = (CMP_W'(head_q) + CMP_W'(1) >= CMP_W'(cap_q)) ? '0 : head_q + PTR_W'(1);
	assign tail_inc = (CMP_W'(tail_q) + CMP_W'(1) >= CMP_W'(cap_q)) ? '0 : tail_q + PTR_W'(1);
	assign tail_dec = (tail_q == '0) ? PTR_W'(cap_q - CNT_W'(1)) : tail_q - PTR_W'(1);

	assign is_full  = (count_q == cap_q);
	assign is_empty = (count_q == '0);

	always_comb begin
		head_nxt  = head_q;
		tail_nxt  = tail_q;
		count_nxt = count_q;
		mem_we    = 1'b0;
		mem_raddr = head_q;
		from_mem  = 1'b0;
		pop_fail  = 1'b0;
		case (cmd_s1.op)
			ord_pkg::OP_PUSH_BACK: begin
				mem_we   = valid_s1;
				tail_nxt = tail_inc;
				if (is_full) begin
					head_nxt = tail_inc;    // overwrite oldest
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			ord_pkg::OP_POP_FRONT: begin
				if (is_empty) begin
					pop_fail = 1'b1;
				end else begin
					from_mem  = 1'b1;
					head_nxt  = head_inc;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			ord_pkg::OP_POP_BACK: begin
				mem_raddr = tail_dec;
				if (is_empty) begin
					pop_fail = 1'b1;
				end else begin
					from_mem  = 1'b1;
					tail_nxt  = tail_dec;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign mem_waddr = tail_q;
	assign mem_wdata = cmd_s1.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cap_q    <= CAP_RST_EFF;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			ctl_s2   <= '0;
		end else begin
			valid_s1     <= accept;
			ctl_s2.valid <= valid_s1;
			if (cfg_we) begin
				cap_q   <= cap_eff;
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else if (valid_s1) begin
				head_q  <= head_nxt;
				tail_q  <= tail_nxt;
				count_q <= count_nxt;
			end
			ctl_s2.from_mem  <= from_mem;
			ctl_s2.status    <= pop_fail;
			ctl_s2.now_empty <= (count_nxt == '0);
			ctl_s2.now_full  <= (count_nxt == cap_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

`ifndef SYNTHESIS
	a_count_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q) else $error("count exceeds capacity");
	a_head_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(head_q) < CMP_W'(cap_q)) else $error("head outside ring");
	a_tail_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(tail_q) < CMP_W'(cap_q)) else $error("tail outside ring");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> ctl_s2.valid) else $error("transaction lost");
	a_fail_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.valid && ctl_s2.status |-> ctl_s2.now_empty && !ctl_s2.from_mem)
		else $error("failed pop on non-empty ring");
`endif

endmodule

// ----- src/overwriting_ring_deque_unit.sv -----
// Overwriting ring deque of signed 32-bit words.
// Command channel: a transaction (cmd.op, cmd.value) is taken at a rising edge
// with start high and busy low. busy stays low, so one transaction per cycle.
// Ops: push back writes at the tail; on a full ring the oldest entry is
// overwritten and the head moves with the tail. Pop front reads the head,
// pop back reads the slot before the tail. A pop on an empty ring returns
// EMPTY_WORD with status set. Every transaction yields exactly one result.
// Result channel: done pulses for one cycle with rsp valid; the receiver
// cannot stall, so results must be taken when shown.
// Result path: input register, then pointer update with registered memory read;
// done and rsp are driven by the latter. Throughput is one transaction per cycle;
// the pointer, count and capacity registers carry all ring control state.
// Config: cfg_we writes capacity (0 acts as 1, above DEPTH acts as DEPTH)
// and empties the ring. Write it only with no transaction in flight.
// Reset: head, tail and count clear, capacity returns to 16 (clamped to
// DEPTH). Word storage is not cleared; the count keeps pops off unwritten slots.
module overwriting_ring_deque_unit #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  ord_pkg::cmd_t              cmd,
	input  logic                       cfg_we,
	input  logic [ord_pkg::CAP_W-1:0]  cfg_wdata,
	output logic                       done,
	output ord_pkg::rsp_t              rsp
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                 mem_we;
	logic [PTR_W-1:0]     mem_waddr, mem_raddr;
	logic signed [31:0]   mem_wdata, mem_rdata;
	ord_pkg::ctl_t        ctl_s2;

	// every cycle can take a new transaction
	assign busy = 1'b0;

	ord_ctrl #(
		.DEPTH (DEPTH),
		.PTR_W (PTR_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (start && !busy),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.ctl_s2    (ctl_s2)
	);

	ord_mem #(
		.DEPTH (DEPTH),
		.PTR_W (PTR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result data: stored word on a good pop, marker on a failed pop, else zero
	always_comb begin
		if (ctl_s2.from_mem) begin
			rsp.data = mem_rdata;
		end else if (ctl_s2.status) begin
			rsp.data = ord_pkg::EMPTY_WORD;
		end else begin
			rsp.data = '0;
		end
		rsp.status    = ctl_s2.status;
		rsp.now_empty = ctl_s2.now_empty;
		rsp.now_full  = ctl_s2.now_full;
	end

	assign done = ctl_s2.valid;

endmodule
